FILE: rtl/afk_pkg.sv
`default_nettype none
package afk_pkg;

	localparam int JOINT_COUNT   = 7;
	localparam int ANGLE_WIDTH   = 16;
	localparam int CORDIC_STEPS  = 30;
	localparam int CORDIC_LAT    = CORDIC_STEPS + 2;
	localparam int CELL_LAT      = 2;
	localparam int OUT_LAT       = 3;
	localparam int LEN_WIDTH     = 20;
	localparam int ROT_WIDTH     = 32;
	localparam int POS_WIDTH     = 40;
	localparam int XW            = 33;
	localparam int ZW            = 34;
	localparam int OUT_WIDTH     = 24;
	localparam int ADDR_WIDTH    = 5;

	// register indexes
	localparam logic [2:0] REG_BASE_HEIGHT   = 3'd0;
	localparam logic [2:0] REG_UPPER_ARM     = 3'd1;
	localparam logic [2:0] REG_FOREARM       = 3'd2;
	localparam logic [2:0] REG_ELBOW_OFFSET  = 3'd3;
	localparam logic [2:0] REG_WRIST_OFFSET  = 3'd4;
	localparam logic [2:0] REG_FLANGE        = 3'd5;

	localparam logic [LEN_WIDTH-1:0] RST_BASE_HEIGHT  = 20'd349176;
	localparam logic [LEN_WIDTH-1:0] RST_UPPER_ARM    = 20'd331350;
	localparam logic [LEN_WIDTH-1:0] RST_FOREARM      = 20'd402653;
	localparam logic [LEN_WIDTH-1:0] RST_ELBOW_OFFSET = 20'd86508;
	localparam logic [LEN_WIDTH-1:0] RST_WRIST_OFFSET = 20'd92275;
	localparam logic [LEN_WIDTH-1:0] RST_FLANGE       = 20'd112198;

	localparam logic signed [ZW-1:0] PI30      = 34'sd3373259426;
	localparam logic signed [ZW-1:0] HALF_PI30 = 34'sd1686629713;
	localparam logic signed [XW-1:0] CORDIC_GAIN30 = 33'sd652032874;
	localparam logic signed [ROT_WIDTH-1:0] ONE30 = 32'sd1073741824;

	typedef logic signed [ROT_WIDTH-1:0] rot_t;
	typedef rot_t [8:0] rmat_t;
	typedef logic signed [POS_WIDTH-1:0] pos_t;
	typedef pos_t [2:0] pvec_t;
	typedef logic signed [OUT_WIDTH-1:0] out_t;

	// arctangent of 2^-i in Q.30
	function automatic logic signed [ZW-1:0] arctan30(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0: r = 34'sd843314857;
			1: r = 34'sd497837829;
			2: r = 34'sd263043837;
			3: r = 34'sd133525159;
			4: r = 34'sd67021687;
			5: r = 34'sd33543516;
			6: r = 34'sd16775851;
			7: r = 34'sd8388437;
			8: r = 34'sd4194283;
			9: r = 34'sd2097149;
			default: r = 34'sd1 <<< (30 - i);
		endcase
		return r;
	endfunction

	// sine of the link twist: 0, -1 or +1
	function automatic int twist_sine(input int j);
		int r;
		case (j)
			0: r = 0;
			1: r = -1;
			2: r = 1;
			3: r = 1;
			4: r = -1;
			5: r = 1;
			default: r = 1;
		endcase
		return r;
	endfunction

	// round Q.60 to Q.30, nearest with ties up
	function automatic logic signed [34:0] round30(input logic signed [64:0] v);
		logic signed [64:0] t;
		t = v + (65'sd1 <<< 29);
		return t[64:30];
	endfunction

	function automatic out_t sat24(input logic signed [39:0] v);
		out_t r;
		if (v > 40'sd8388607)
			r = 24'sh7FFFFF;
		else if (v < -40'sd8388608)
			r = 24'sh800000;
		else
			r = v[23:0];
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/afk_cordic_cell.sv
`default_nettype none
module afk_cordic_cell #(
	parameter int STEP = 0
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_vld,
	input  wire                                in_flip,
	input  wire logic signed [afk_pkg::XW-1:0] in_x,
	input  wire logic signed [afk_pkg::XW-1:0] in_y,
	input  wire logic signed [afk_pkg::ZW-1:0] in_z,
	output logic                               out_vld,
	output logic                               out_flip,
	output logic signed [afk_pkg::XW-1:0]      out_x,
	output logic signed [afk_pkg::XW-1:0]      out_y,
	output logic signed [afk_pkg::ZW-1:0]      out_z
);
	localparam logic signed [afk_pkg::ZW-1:0] ATAN = afk_pkg::arctan30(STEP);

	logic signed [afk_pkg::XW-1:0] dx, dy;

	assign dx = in_y >>> STEP;
	assign dy = in_x >>> STEP;

	// advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld <= 1'b0;
		else
			out_vld <= in_vld;
	end

	// rotate toward zero residual angle
	always_ff @(posedge clk) begin
		out_flip <= in_flip;
		if (!in_z[afk_pkg::ZW-1]) begin
			out_x <= in_x - dx;
			out_y <= in_y + dy;
			out_z <= in_z - ATAN;
		end else begin
			out_x <= in_x + dx;
			out_y <= in_y - dy;
			out_z <= in_z + ATAN;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/afk_cordic.sv
`default_nettype none
module afk_cordic #(
	parameter int ANGLE_WIDTH = afk_pkg::ANGLE_WIDTH
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_vld,
	input  wire logic signed [ANGLE_WIDTH-1:0] angle,
	output logic                              out_vld,
	output afk_pkg::rot_t                     sin_v,
	output afk_pkg::rot_t                     cos_v
);
	localparam int STEPS = afk_pkg::CORDIC_STEPS;
	localparam int SHIFT = 33 - ANGLE_WIDTH;

	logic signed [afk_pkg::ZW-1:0] t;
	logic                          vld_c [STEPS+1];
	logic                          flip_c [STEPS+1];
	logic signed [afk_pkg::XW-1:0] x_c [STEPS+1];
	logic signed [afk_pkg::XW-1:0] y_c [STEPS+1];
	logic signed [afk_pkg::ZW-1:0] z_c [STEPS+1];

	assign t = afk_pkg::ZW'(angle) <<< SHIFT;

	// reduce the angle into [-pi/2, pi/2]
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_c[0] <= 1'b0;
		else
			vld_c[0] <= in_vld;
	end

	always_ff @(posedge clk) begin
		x_c[0] <= afk_pkg::CORDIC_GAIN30;
		y_c[0] <= '0;
		if (t > afk_pkg::HALF_PI30) begin
			z_c[0]    <= t - afk_pkg::PI30;
			flip_c[0] <= 1'b1;
		end else if (t < -afk_pkg::HALF_PI30) begin
			z_c[0]    <= t + afk_pkg::PI30;
			flip_c[0] <= 1'b1;
		end else begin
			z_c[0]    <= t;
			flip_c[0] <= 1'b0;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		afk_cordic_cell #(.STEP(i)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_vld  (vld_c[i]),
			.in_flip (flip_c[i]),
			.in_x    (x_c[i]),
			.in_y    (y_c[i]),
			.in_z    (z_c[i]),
			.out_vld (vld_c[i+1]),
			.out_flip(flip_c[i+1]),
			.out_x   (x_c[i+1]),
			.out_y   (y_c[i+1]),
			.out_z   (z_c[i+1])
		);
	end

	// undo the half-turn reduction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld <= 1'b0;
		else
			out_vld <= vld_c[STEPS];
	end

	always_ff @(posedge clk) begin
		if (flip_c[STEPS]) begin
			cos_v <= afk_pkg::rot_t'(-x_c[STEPS]);
			sin_v <= afk_pkg::rot_t'(-y_c[STEPS]);
		end else begin
			cos_v <= afk_pkg::rot_t'(x_c[STEPS]);
			sin_v <= afk_pkg::rot_t'(y_c[STEPS]);
		end
	end
endmodule
`default_nettype wire

FILE: rtl/afk_joint_cell.sv
`default_nettype none
module afk_joint_cell #(
	parameter int JOINT = 0
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_vld,
	input  wire afk_pkg::rmat_t in_rot,
	input  wire afk_pkg::pvec_t in_pos,
	input  wire                 sc_vld,
	input  wire afk_pkg::rot_t  sin_v,
	input  wire afk_pkg::rot_t  cos_v,
	input  wire afk_pkg::rot_t  len_a,
	input  wire afk_pkg::rot_t  len_d,
	output logic                out_vld,
	output afk_pkg::rmat_t      out_rot,
	output afk_pkg::pvec_t      out_pos
);
	localparam int SA = afk_pkg::twist_sine(JOINT);
	localparam bit CA = (SA == 0);
	localparam int KM = CA ? 1 : 2;
	localparam int KP = CA ? 2 : 1;
	localparam bit NEG_M = (SA < 0);
	localparam bit NEG_P = (SA > 0);

	logic                 vld_s1;
	logic signed [63:0]   mco0_s1 [3];
	logic signed [63:0]   ms1_s1  [3];
	logic signed [63:0]   ms0_s1  [3];
	logic signed [63:0]   mco1_s1 [3];
	logic signed [63:0]   mpa_s1  [3];
	logic signed [63:0]   mpd_s1  [3];
	afk_pkg::rot_t        c2_s1   [3];
	afk_pkg::pvec_t       pos_s1;

	// hold valid through both stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			vld_s1  <= in_vld;
			out_vld <= vld_s1;
		end
	end

	for (genvar r = 0; r < 3; r++) begin : g_row
		logic signed [64:0] sum0, sum1, acc;

		// stage 1: partial products of row r
		always_ff @(posedge clk) begin
			mco0_s1[r] <= $signed(in_rot[r*3]) * $signed(cos_v);
			ms1_s1[r]  <= $signed(in_rot[r*3+KM]) * $signed(sin_v);
			ms0_s1[r]  <= $signed(in_rot[r*3]) * $signed(sin_v);
			mco1_s1[r] <= $signed(in_rot[r*3+KM]) * $signed(cos_v);
			mpa_s1[r]  <= $signed(in_rot[r*3]) * $signed(len_a);
			mpd_s1[r]  <= $signed(in_rot[r*3+KP]) * $signed(len_d);
			if (CA)
				c2_s1[r] <= in_rot[r*3+2];
			else if (NEG_P)
				c2_s1[r] <= -$signed(in_rot[r*3+1]);
			else
				c2_s1[r] <= in_rot[r*3+1];
		end

		// stage 2: sum the terms and round back to Q.30
		always_comb begin
			sum0 = 65'(mco0_s1[r]) + (NEG_M ? -65'(ms1_s1[r]) : 65'(ms1_s1[r]));
			sum1 = -65'(ms0_s1[r]) + (NEG_M ? -65'(mco1_s1[r]) : 65'(mco1_s1[r]));
			acc  = 65'(mpa_s1[r]) + (NEG_P ? -65'(mpd_s1[r]) : 65'(mpd_s1[r]));
		end

		always_ff @(posedge clk) begin
			out_rot[r*3]   <= afk_pkg::rot_t'(afk_pkg::round30(sum0));
			out_rot[r*3+1] <= afk_pkg::rot_t'(afk_pkg::round30(sum1));
			out_rot[r*3+2] <= c2_s1[r];
			out_pos[r]     <= pos_s1[r] + afk_pkg::pos_t'(afk_pkg::round30(acc));
		end
	end

	always_ff @(posedge clk) begin
		pos_s1 <= in_pos;
	end

	// the sine and cosine lane must line up with the chain
	a_sc_align: assert property (@(posedge clk) disable iff (!arst_n)
		in_vld == sc_vld)
		else $error("sine/cosine lane out of step with joint chain");
endmodule
`default_nettype wire

FILE: rtl/afk_out.sv
`default_nettype none
module afk_out (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     in_vld,
	input  wire afk_pkg::rmat_t                     in_rot,
	input  wire afk_pkg::pvec_t                     in_pos,
	input  wire logic [afk_pkg::LEN_WIDTH-1:0]      flange,
	output logic                                    out_vld,
	output afk_pkg::out_t                           pos_o [3],
	output afk_pkg::out_t                           rot_o [9]
);
	logic               vld_s1, vld_s2;
	logic signed [63:0] mf_s1 [3];
	afk_pkg::rmat_t     rot_s1, rot_s2;
	afk_pkg::pvec_t     pos_s1, pos_s2;
	afk_pkg::rot_t      flen;

	assign flen = afk_pkg::rot_t'({flange, 10'd0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			out_vld <= vld_s2;
		end
	end

	for (genvar r = 0; r < 3; r++) begin : g_row
		logic signed [39:0] pr;
		assign pr = (pos_s2[r] + 40'sd512) >>> 10;

		// flange offset along the last z axis
		always_ff @(posedge clk) begin
			mf_s1[r]  <= $signed(in_rot[r*3+2]) * $signed(flen);
			pos_s2[r] <= pos_s1[r] + afk_pkg::pos_t'(afk_pkg::round30(65'(mf_s1[r])));
			pos_o[r]  <= afk_pkg::sat24(pr);
		end
	end

	for (genvar e = 0; e < 9; e++) begin : g_rot
		logic signed [39:0] rr;
		assign rr = (40'(rot_s2[e]) + 40'sd128) >>> 8;

		always_ff @(posedge clk) begin
			rot_o[e] <= afk_pkg::sat24(rr);
		end
	end

	always_ff @(posedge clk) begin
		rot_s1 <= in_rot;
		pos_s1 <= in_pos;
		rot_s2 <= rot_s1;
	end
endmodule
`default_nettype wire

FILE: rtl/arm_forward_kinematics_dh_unit.sv
// Pose pipeline: seven CORDIC lanes feed a chain of seven joint cells.
// A start beat passes through the CORDIC lane, the joint cells and the flange and
//   output rounding to the done strobe.
// Throughput: one angle set per cycle; busy stays low, done cannot be stalled.
// Reset: arst_n clears all valid flags and restores the length registers
//   to their default values.
`default_nettype none
module arm_forward_kinematics_dh_unit #(
	parameter int ANGLE_WIDTH = afk_pkg::ANGLE_WIDTH
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	output logic                                busy,
	input  wire logic signed [ANGLE_WIDTH-1:0]  joint_angle_1,
	input  wire logic signed [ANGLE_WIDTH-1:0]  joint_angle_2,
	input  wire logic signed [ANGLE_WIDTH-1:0]  joint_angle_3,
	input  wire logic signed [ANGLE_WIDTH-1:0]  joint_angle_4,
	input  wire logic signed [ANGLE_WIDTH-1:0]  joint_angle_5,
	input  wire logic signed [ANGLE_WIDTH-1:0]  joint_angle_6,
	input  wire logic signed [ANGLE_WIDTH-1:0]  joint_angle_7,
	output logic                                done,
	output logic signed [23:0]                  pos_x,
	output logic signed [23:0]                  pos_y,
	output logic signed [23:0]                  pos_z,
	output logic signed [23:0]                  rot_00,
	output logic signed [23:0]                  rot_01,
	output logic signed [23:0]                  rot_02,
	output logic signed [23:0]                  rot_10,
	output logic signed [23:0]                  rot_11,
	output logic signed [23:0]                  rot_12,
	output logic signed [23:0]                  rot_20,
	output logic signed [23:0]                  rot_21,
	output logic signed [23:0]                  rot_22,
	input  wire                                 psel,
	input  wire                                 penable,
	input  wire                                 pwrite,
	input  wire [afk_pkg::ADDR_WIDTH-1:0]       paddr,
	input  wire [31:0]                          pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	localparam int NJ = afk_pkg::JOINT_COUNT;
	localparam int LW = afk_pkg::LEN_WIDTH;
	localparam int LATENCY = afk_pkg::CORDIC_LAT + afk_pkg::CELL_LAT * NJ + afk_pkg::OUT_LAT;

	logic [LW-1:0] base_height_q, upper_arm_q, forearm_q, elbow_q, wrist_q, flange_q;
	logic          wr_en;
	logic [2:0]    reg_idx;

	logic signed [ANGLE_WIDTH-1:0] angle_in [NJ];
	logic signed [ANGLE_WIDTH-1:0] lane_ang [NJ];
	logic                          lane_vld [NJ];
	logic                          sc_vld [NJ];
	afk_pkg::rot_t                 sin_v [NJ];
	afk_pkg::rot_t                 cos_v [NJ];
	afk_pkg::rot_t                 len_a [NJ];
	afk_pkg::rot_t                 len_d [NJ];
	afk_pkg::rot_t                 elb;
	logic                          ch_vld [NJ+1];
	afk_pkg::rmat_t                ch_rot [NJ+1];
	afk_pkg::pvec_t                ch_pos [NJ+1];
	afk_pkg::out_t                 pos_o [3];
	afk_pkg::out_t                 rot_o [9];

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign reg_idx = paddr[4:2];

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_height_q <= afk_pkg::RST_BASE_HEIGHT;
			upper_arm_q   <= afk_pkg::RST_UPPER_ARM;
			forearm_q     <= afk_pkg::RST_FOREARM;
			elbow_q       <= afk_pkg::RST_ELBOW_OFFSET;
			wrist_q       <= afk_pkg::RST_WRIST_OFFSET;
			flange_q      <= afk_pkg::RST_FLANGE;
		end else if (wr_en) begin
			unique case (reg_idx)
				afk_pkg::REG_BASE_HEIGHT:  base_height_q <= pwdata[LW-1:0];
				afk_pkg::REG_UPPER_ARM:    upper_arm_q   <= pwdata[LW-1:0];
				afk_pkg::REG_FOREARM:      forearm_q     <= pwdata[LW-1:0];
				afk_pkg::REG_ELBOW_OFFSET: elbow_q       <= pwdata[LW-1:0];
				afk_pkg::REG_WRIST_OFFSET: wrist_q       <= pwdata[LW-1:0];
				afk_pkg::REG_FLANGE:       flange_q      <= pwdata[LW-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (reg_idx)
			afk_pkg::REG_BASE_HEIGHT:  prdata = 32'(base_height_q);
			afk_pkg::REG_UPPER_ARM:    prdata = 32'(upper_arm_q);
			afk_pkg::REG_FOREARM:      prdata = 32'(forearm_q);
			afk_pkg::REG_ELBOW_OFFSET: prdata = 32'(elbow_q);
			afk_pkg::REG_WRIST_OFFSET: prdata = 32'(wrist_q);
			afk_pkg::REG_FLANGE:       prdata = 32'(flange_q);
			default:                   prdata = '0;
		endcase
	end

	// link lengths and offsets in Q.30
	assign elb = afk_pkg::rot_t'({elbow_q, 10'd0});
	always_comb begin
		for (int j = 0; j < NJ; j++) begin
			len_a[j] = '0;
			len_d[j] = '0;
		end
		len_d[0] = afk_pkg::rot_t'({base_height_q, 10'd0});
		len_d[2] = afk_pkg::rot_t'({upper_arm_q, 10'd0});
		len_d[4] = afk_pkg::rot_t'({forearm_q, 10'd0});
		len_a[3] = elb;
		len_a[4] = -elb;
		len_a[6] = afk_pkg::rot_t'({wrist_q, 10'd0});
	end

	assign angle_in[0] = joint_angle_1;
	assign angle_in[1] = joint_angle_2;
	assign angle_in[2] = joint_angle_3;
	assign angle_in[3] = joint_angle_4;
	assign angle_in[4] = joint_angle_5;
	assign angle_in[5] = joint_angle_6;
	assign angle_in[6] = joint_angle_7;

	// delay each lane so its sine and cosine meet the chain at its joint cell
	for (genvar j = 0; j < NJ; j++) begin : g_lane
		localparam int D = afk_pkg::CELL_LAT * j;
		if (D == 0) begin : g_direct
			assign lane_ang[j] = angle_in[j];
			assign lane_vld[j] = start;
		end else begin : g_delay
			logic signed [ANGLE_WIDTH-1:0] ang_q [D];
			logic                          vld_q [D];
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					for (int k = 0; k < D; k++)
						vld_q[k] <= 1'b0;
				end else begin
					vld_q[0] <= start;
					for (int k = 1; k < D; k++)
						vld_q[k] <= vld_q[k-1];
				end
			end
			always_ff @(posedge clk) begin
				ang_q[0] <= angle_in[j];
				for (int k = 1; k < D; k++)
					ang_q[k] <= ang_q[k-1];
			end
			assign lane_ang[j] = ang_q[D-1];
			assign lane_vld[j] = vld_q[D-1];
		end

		afk_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic (
			.clk    (clk),
			.arst_n (arst_n),
			.in_vld (lane_vld[j]),
			.angle  (lane_ang[j]),
			.out_vld(sc_vld[j]),
			.sin_v  (sin_v[j]),
			.cos_v  (cos_v[j])
		);
	end

	// chain starts from the identity pose
	assign ch_vld[0] = sc_vld[0];
	always_comb begin
		for (int e = 0; e < 9; e++)
			ch_rot[0][e] = (e % 4 == 0) ? afk_pkg::ONE30 : '0;
		for (int r = 0; r < 3; r++)
			ch_pos[0][r] = '0;
	end

	for (genvar j = 0; j < NJ; j++) begin : g_joint
		afk_joint_cell #(.JOINT(j)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.in_vld (ch_vld[j]),
			.in_rot (ch_rot[j]),
			.in_pos (ch_pos[j]),
			.sc_vld (sc_vld[j]),
			.sin_v  (sin_v[j]),
			.cos_v  (cos_v[j]),
			.len_a  (len_a[j]),
			.len_d  (len_d[j]),
			.out_vld(ch_vld[j+1]),
			.out_rot(ch_rot[j+1]),
			.out_pos(ch_pos[j+1])
		);
	end

	afk_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (ch_vld[NJ]),
		.in_rot (ch_rot[NJ]),
		.in_pos (ch_pos[NJ]),
		.flange (flange_q),
		.out_vld(done),
		.pos_o  (pos_o),
		.rot_o  (rot_o)
	);

	assign pos_x  = pos_o[0];
	assign pos_y  = pos_o[1];
	assign pos_z  = pos_o[2];
	assign rot_00 = rot_o[0];
	assign rot_01 = rot_o[1];
	assign rot_02 = rot_o[2];
	assign rot_10 = rot_o[3];
	assign rot_11 = rot_o[4];
	assign rot_12 = rot_o[5];
	assign rot_20 = rot_o[6];
	assign rot_21 = rot_o[7];
	assign rot_22 = rot_o[8];

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("start beat not answered after fixed latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("done strobe without matching start beat");

	a_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!wr_en |=> $stable(base_height_q) && $stable(flange_q) && $stable(elbow_q))
		else $error("length register changed without a write");
endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;

	typedef logic signed [11:0][23:0] pose_t;
	typedef logic [6:0][15:0] joint_set_t;

	localparam logic [2:0] REG_SPARE = 3'd6;
	localparam int TWIST_SINE [7] = '{0, -1, 1, 1, -1, 1, 1};
	localparam int SETTLE_CYCLES = 60;
	localparam logic [15:0] HALF_PI_Q13 = 16'd12868;
	localparam logic [15:0] PI_Q13 = 16'd25736;

	// directed angle sets: joint 7 is element 6
	localparam int DIRECTED_COUNT = 16;
	localparam joint_set_t DIRECTED [DIRECTED_COUNT] = '{
		{7{16'h0000}},
		{7{16'h7FFF}},
		{7{16'h8000}},
		{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF},
		{7{16'h0001}},
		{7{16'hFFFF}},
		{7{HALF_PI_Q13}},
		{7{HALF_PI_Q13 + 16'd1}},
		{7{HALF_PI_Q13 - 16'd1}},
		{7{-HALF_PI_Q13}},
		{7{-HALF_PI_Q13 - 16'd1}},
		{7{PI_Q13}},
		{7{-PI_Q13}},
		{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, HALF_PI_Q13},
		{HALF_PI_Q13, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
		{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	joint_set_t angles = '0;
	logic done;
	pose_t pose_out;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [afk_pkg::ADDR_WIDTH-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	logic [19:0] link_len [6];
	pose_t pose_q [$];
	int mismatches = 0;
	int burst_left = 0;

	arm_forward_kinematics_dh_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.joint_angle_1(angles[0]), .joint_angle_2(angles[1]),
		.joint_angle_3(angles[2]), .joint_angle_4(angles[3]),
		.joint_angle_5(angles[4]), .joint_angle_6(angles[5]),
		.joint_angle_7(angles[6]),
		.done(done),
		.pos_x(pose_out[0]), .pos_y(pose_out[1]), .pos_z(pose_out[2]),
		.rot_00(pose_out[3]), .rot_01(pose_out[4]), .rot_02(pose_out[5]),
		.rot_10(pose_out[6]), .rot_11(pose_out[7]), .rot_12(pose_out[8]),
		.rot_20(pose_out[9]), .rot_21(pose_out[10]), .rot_22(pose_out[11]),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #10 clk = ~clk;

	function automatic longint round_to(input longint v, input int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [23:0] clamp24(input longint v);
		if (v > 8388607)
			return 24'sh7FFFFF;
		if (v < -8388608)
			return 24'sh800000;
		return v[23:0];
	endfunction

	function automatic longint arctan_q30(input int i);
		case (i)
			0: return 843314857;
			1: return 497837829;
			2: return 263043837;
			3: return 133525159;
			4: return 67021687;
			5: return 33543516;
			6: return 16775851;
			7: return 8388437;
			8: return 4194283;
			default: return 2097149;
		endcase
	endfunction

	// sine and cosine in Q.30 by rotation-mode CORDIC with half-turn folding
	task automatic joint_sin_cos(input longint t, output longint sn, output longint cs);
		longint x, y, z, dx, dy, step;
		bit flip;
		x = 64'sd652032874;
		y = 0;
		flip = 1'b0;
		if (t > 64'sd1686629713) begin
			t -= 64'sd3373259426;
			flip = 1'b1;
		end else if (t < -64'sd1686629713) begin
			t += 64'sd3373259426;
			flip = 1'b1;
		end
		z = t;
		for (int i = 0; i < afk_pkg::CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			step = (i < 10) ? longint'(arctan_q30(i)) : (64'sd1 <<< (30 - i));
			if (z >= 0) begin
				x -= dx; y += dy; z -= step;
			end else begin
				x += dx; y -= dy; z += step;
			end
		end
		cs = flip ? -x : x;
		sn = flip ? -y : y;
	endtask

	// chain the seven link transforms and the flange, then round and clamp
	task automatic predict_pose(input joint_set_t a, output pose_t res);
		longint rm [3][3], lr [3][3], nr [3][3];
		longint pv [3], lp [3], la [7], ld [7];
		longint sn, cs, sa, ca, acc, sum;
		for (int r = 0; r < 3; r++) begin
			pv[r] = 0;
			for (int c = 0; c < 3; c++)
				rm[r][c] = (r == c) ? (64'sd1 <<< 30) : 0;
		end
		for (int j = 0; j < 7; j++) begin
			la[j] = 0;
			ld[j] = 0;
		end
		ld[0] = longint'(link_len[afk_pkg::REG_BASE_HEIGHT]) <<< 10;
		ld[2] = longint'(link_len[afk_pkg::REG_UPPER_ARM]) <<< 10;
		ld[4] = longint'(link_len[afk_pkg::REG_FOREARM]) <<< 10;
		la[3] = longint'(link_len[afk_pkg::REG_ELBOW_OFFSET]) <<< 10;
		la[4] = -la[3];
		la[6] = longint'(link_len[afk_pkg::REG_WRIST_OFFSET]) <<< 10;
		for (int j = 0; j < 7; j++) begin
			joint_sin_cos(longint'($signed(a[j])) <<< 17, sn, cs);
			sa = TWIST_SINE[j];
			ca = (sa == 0) ? 1 : 0;
			lr[0][0] = cs;      lr[0][1] = -sn;     lr[0][2] = 0;
			lr[1][0] = sn * ca; lr[1][1] = cs * ca; lr[1][2] = -sa * (64'sd1 <<< 30);
			lr[2][0] = sn * sa; lr[2][1] = cs * sa; lr[2][2] = ca * (64'sd1 <<< 30);
			lp[0] = la[j];
			lp[1] = -ld[j] * sa;
			lp[2] = ld[j] * ca;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					sum = 0;
					for (int k = 0; k < 3; k++)
						sum += rm[r][k] * lr[k][c];
					nr[r][c] = round_to(sum, 30);
				end
				acc = 0;
				for (int k = 0; k < 3; k++)
					acc += rm[r][k] * lp[k];
				pv[r] += round_to(acc, 30);
			end
			rm = nr;
		end
		for (int r = 0; r < 3; r++) begin
			pv[r] += round_to(rm[r][2] *
				(longint'(link_len[afk_pkg::REG_FLANGE]) <<< 10), 30);
			res[r] = clamp24(round_to(pv[r], 10));
			for (int c = 0; c < 3; c++)
				res[3 + r * 3 + c] = clamp24(round_to(rm[r][c], 8));
		end
	endtask

	task automatic report(input int field, input logic [23:0] got, input logic [23:0] want);
		$display("mismatch at %0t: field %0d got %0d want %0d",
			$time, field, $signed(got), $signed(want));
		mismatches++;
	endtask

	// log accepted beats and check each done strobe against the oldest pose
	always @(posedge clk) begin
		pose_t want;
		if (arst_n) begin
			if (start && !busy) begin
				predict_pose(angles, want);
				pose_q.push_back(want);
			end
			if (done) begin
				if (pose_q.size() == 0) begin
					$display("unexpected pose at %0t", $time);
					mismatches++;
				end else begin
					want = pose_q.pop_front();
					for (int f = 0; f < 12; f++)
						if (pose_out[f] !== want[f])
							report(f, pose_out[f], want[f]);
				end
			end
		end
	end

	// setup, access, then idle before the next transfer
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx <= afk_pkg::REG_FLANGE)
			link_len[idx] = val[19:0];
		@(posedge clk);
	endtask

	// hold the beat until accepted; insert a random gap between bursts
	task automatic send_joints(input joint_set_t a);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		angles <= a;
		do
			@(negedge clk);
		while (busy);
		@(posedge clk);
	endtask

	function automatic logic [15:0] random_angle();
		logic [15:0] edge_pt;
		if ($urandom_range(0, 3) != 0)
			return $urandom_range(0, 65535);
		case ($urandom_range(0, 3))
			0: edge_pt = HALF_PI_Q13;
			1: edge_pt = -HALF_PI_Q13;
			2: edge_pt = PI_Q13;
			default: edge_pt = -PI_Q13;
		endcase
		return edge_pt + 16'($urandom_range(0, 6)) - 16'd3;
	endfunction

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pose_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		joint_set_t a;
		link_len[afk_pkg::REG_BASE_HEIGHT] = afk_pkg::RST_BASE_HEIGHT;
		link_len[afk_pkg::REG_UPPER_ARM] = afk_pkg::RST_UPPER_ARM;
		link_len[afk_pkg::REG_FOREARM] = afk_pkg::RST_FOREARM;
		link_len[afk_pkg::REG_ELBOW_OFFSET] = afk_pkg::RST_ELBOW_OFFSET;
		link_len[afk_pkg::REG_WRIST_OFFSET] = afk_pkg::RST_WRIST_OFFSET;
		link_len[afk_pkg::REG_FLANGE] = afk_pkg::RST_FLANGE;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int phase = 0; phase < 5; phase++) begin
			// retune the arm between phases, with the block idle
			for (int r = afk_pkg::REG_BASE_HEIGHT; r <= afk_pkg::REG_FLANGE; r++)
				case (phase)
					1: write_reg(3'(r), 32'h0);
					2: write_reg(3'(r), 32'hFFFF_FFFF);
					3, 4: write_reg(3'(r), $urandom);
					default: ;
				endcase
			if (phase == 1)
				write_reg(REG_SPARE, $urandom);
			if (phase == 0)
				for (int d = 0; d < DIRECTED_COUNT; d++)
					send_joints(DIRECTED[d]);
			for (int n = 0; n < 360; n++) begin
				for (int j = 0; j < 7; j++)
					a[j] = random_angle();
				send_joints(a);
			end
			drain();
		end

		if (mismatches == 0 && pose_q.size() == 0)
			$display("arm_forward_kinematics_dh_unit regression: pass");
		else
			$display("arm_forward_kinematics_dh_unit regression: fail");
		$finish;
	end

	initial begin
		#5ms;
		$display("arm_forward_kinematics_dh_unit regression: fail");
		$finish;
	end

endmodule
